// ===== design/dtpb_pkg.sv =====
// Types and constants shared by the drop-tail packet buffer control and top modules.
// No dependencies.
`default_nettype none

package dtpb_pkg;

    localparam int BUF_SIZE_W   = 7;
    localparam int ARRIVAL_W    = 32;
    localparam int PROCESS_W    = 16;
    localparam int START_W      = 32;

    localparam logic [BUF_SIZE_W-1:0] BUF_SIZE_RESET = 7'd64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic               dropped;
        logic [START_W-1:0] start_tick;
    } result_t;

endpackage

`default_nettype wire

// ===== design/dtpb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dtpb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/dtpb_ctrl.sv =====
// Queue control: retires due finish times, decides accept or drop, pushes finish times.
// Depends on dtpb_pkg; drives the finish-time RAM (dtpb_ram) ports.
`default_nettype none

module dtpb_ctrl #(
    parameter int MAX_DEPTH = 64,
    parameter int TIME_BITS = 32,
    parameter int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
    input  wire logic                              clk,
    input  wire logic                              rstn,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [dtpb_pkg::ARRIVAL_W-1:0]    arrive_tick,
    input  wire logic [dtpb_pkg::PROCESS_W-1:0]    service_ticks,
    input  wire logic [dtpb_pkg::BUF_SIZE_W-1:0]   buffer_size,
    input  wire logic                              out_free,
    output logic                                   res_load,
    output dtpb_pkg::result_t                      res,
    output logic                                   ram_we,
    output logic      [IDX_W-1:0]                  ram_waddr,
    output logic      [TIME_BITS-1:0]              ram_wdata,
    output logic      [IDX_W-1:0]                  ram_raddr,
    input  wire logic [TIME_BITS-1:0]              ram_rdata
);

    import dtpb_pkg::*;

    localparam int OCC_W = $clog2(MAX_DEPTH + 1);
    localparam int CMP_W = (OCC_W > BUF_SIZE_W) ? OCC_W : BUF_SIZE_W;
    localparam int SUM_W = IDX_W + 1;

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       head_reg, head_next;
    logic [OCC_W-1:0]       occ_reg, occ_next;
    logic [TIME_BITS-1:0]   arrival_reg, arrival_next;
    logic [PROCESS_W-1:0]   service_reg, service_next;
    logic [TIME_BITS-1:0]   head_val_reg, head_val_next;
    logic [TIME_BITS-1:0]   tail_val_reg, tail_val_next;

    logic                   head_due;
    logic                   full;
    logic                   pop;
    logic                   finish_item;
    logic                   push;
    logic [CMP_W-1:0]       capacity;
    logic [TIME_BITS-1:0]   start;
    logic [TIME_BITS:0]     sum;
    logic [TIME_BITS-1:0]   finish;
    logic [SUM_W-1:0]       head_inc_sum;
    logic [SUM_W-1:0]       push_sum;
    logic [IDX_W-1:0]       head_inc;
    logic [IDX_W-1:0]       push_slot;

    // Datapath
    always_comb begin
        head_due = (occ_reg != '0) && (head_val_reg <= arrival_reg);
        capacity = (CMP_W'(buffer_size) > CMP_W'(MAX_DEPTH)) ? CMP_W'(MAX_DEPTH)
                                                              : CMP_W'(buffer_size);
        full     = CMP_W'(occ_reg) >= capacity;
        start    = (occ_reg != '0) ? tail_val_reg : arrival_reg;
        sum      = {1'b0, start} + (TIME_BITS + 1)'(service_reg);
        finish   = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];

        head_inc_sum = SUM_W'(head_reg) + SUM_W'(1);
        head_inc     = (head_inc_sum >= SUM_W'(MAX_DEPTH))
                       ? IDX_W'(head_inc_sum - SUM_W'(MAX_DEPTH)) : IDX_W'(head_inc_sum);
        push_sum     = SUM_W'(head_reg) + SUM_W'(occ_reg);
        push_slot    = (push_sum >= SUM_W'(MAX_DEPTH))
                       ? IDX_W'(push_sum - SUM_W'(MAX_DEPTH)) : IDX_W'(push_sum);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (head_due) begin
                    state_next = (occ_reg > OCC_W'(1)) ? ST_LOAD : ST_CHECK;
                end else if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD: begin
                state_next = ST_CHECK;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        in_ready    = 1'b0;
        pop         = 1'b0;
        finish_item = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
            end
            ST_CHECK: begin
                pop         = head_due;
                finish_item = !head_due && out_free;
            end
            ST_LOAD: begin
            end
            default: begin
            end
        endcase
        push           = finish_item && !full;
        res_load       = finish_item;
        res.dropped    = full;
        res.start_tick = full ? '0 : START_W'(start);
        ram_we         = push;
        ram_waddr      = push_slot;
        ram_wdata      = finish;
        ram_raddr      = head_inc;
    end

    // Register updates
    always_comb begin
        head_next     = head_reg;
        occ_next      = occ_reg;
        arrival_next  = arrival_reg;
        service_next  = service_reg;
        head_val_next = head_val_reg;
        tail_val_next = tail_val_reg;
        if (in_ready && in_valid) begin
            arrival_next = TIME_BITS'(arrive_tick);
            service_next = service_ticks;
        end
        if (pop) begin
            head_next = head_inc;
            occ_next  = occ_reg - OCC_W'(1);
        end
        if (state_reg == ST_LOAD) begin
            head_val_next = ram_rdata;
        end
        if (push) begin
            occ_next      = occ_reg + OCC_W'(1);
            tail_val_next = finish;
            if (occ_reg == '0) begin
                head_val_next = finish;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            occ_reg   <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            occ_reg   <= occ_next;
        end
        arrival_reg  <= arrival_next;
        service_reg  <= service_next;
        head_val_reg <= head_val_next;
        tail_val_reg <= tail_val_next;
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rstn)
        occ_reg <= OCC_W'(MAX_DEPTH))
        else $error("occupancy above depth");

    a_push_count: assert property (@(posedge clk) disable iff (!rstn)
        ram_we |=> occ_reg == $past(occ_reg) + OCC_W'(1))
        else $error("push did not advance occupancy");

    a_pop_count: assert property (@(posedge clk) disable iff (!rstn)
        pop |=> occ_reg == $past(occ_reg) - OCC_W'(1))
        else $error("retire did not reduce occupancy");

    a_load_after_check: assert property (@(posedge clk) disable iff (!rstn)
        (state_reg == ST_LOAD) |-> ($past(state_reg) == ST_CHECK && $past(pop)))
        else $error("head load without retire");

endmodule

`default_nettype wire

// ===== design/drop_tail_packet_buffer.sv =====
// Drop-tail packet buffer: single-server queue with bounded capacity.
//
// Channels: s_ carries one packet per item (arrival tick, service ticks); m_ returns one
// result per item (dropped flag, service start tick). cfg_ writes buffer_size, the number
// of packets held including the one in service, clamped to MAX_DEPTH; 0 drops everything.
// Write it only while the block is idle. cfg_ready is always high.
// Queued finish ticks live in a MAX_DEPTH-entry RAM; the newest and oldest finish ticks
// are also held in registers, so only retiring needs RAM reads.
// Sequence: an item is accepted, then decided; before the decision each due entry is retired
// by a head compare and then a RAM read of the next head, with no read for the retire that
// empties the queue. The decision loads the result into the output register; the next item
// is accepted only after that, so one packet is handled at a time.
// If the receiver stalls, the decision waits until the output register is free, and the
// item already there stays on m_ unchanged.
// Reset (aresetn low, synchronous) empties the queue, clears the output valid flag and
// sets buffer_size to 64. The RAM needs no clearing pass.
// Depends on dtpb_pkg, dtpb_ram, dtpb_ctrl.
`default_nettype none

module drop_tail_packet_buffer #(
    parameter int MAX_DEPTH = 64,
    parameter int TIME_BITS = 32
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [dtpb_pkg::BUF_SIZE_W-1:0]  cfg_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [dtpb_pkg::ARRIVAL_W-1:0]   s_arrive_tick,
    input  wire logic [dtpb_pkg::PROCESS_W-1:0]   s_service_ticks,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_dropped,
    output logic      [dtpb_pkg::START_W-1:0]     m_start_tick
);

    import dtpb_pkg::*;

    localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    logic [BUF_SIZE_W-1:0]  buf_size_reg, buf_size_next;
    logic                   m_valid_reg, m_valid_next;
    result_t                res_reg, res_next;

    logic                   out_free;
    logic                   res_load;
    result_t                res;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [TIME_BITS-1:0]   ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;
    logic [TIME_BITS-1:0]   ram_rdata;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    dtpb_ctrl #(
        .MAX_DEPTH (MAX_DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .clk           (aclk),
        .rstn          (aresetn),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .arrive_tick   (s_arrive_tick),
        .service_ticks (s_service_ticks),
        .buffer_size   (buf_size_reg),
        .out_free      (out_free),
        .res_load      (res_load),
        .res           (res),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata)
    );

    dtpb_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (MAX_DEPTH)
    ) u_finish_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        buf_size_next = buf_size_reg;
        m_valid_next  = m_valid_reg;
        res_next      = res_reg;
        if (cfg_valid) begin
            buf_size_next = cfg_data;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_load) begin
            m_valid_next = 1'b1;
            res_next     = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_size_reg <= BUF_SIZE_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            buf_size_reg <= buf_size_next;
            m_valid_reg  <= m_valid_next;
        end
        res_reg <= res_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_dropped    = res_reg.dropped;
    assign m_start_tick = res_reg.start_tick;

endmodule

`default_nettype wire
